// ----- rtl/core/fts_pkg.sv -----
// Shared constants and types for the FIFO thread scheduler.
`timescale 1ns / 1ps
package fts_pkg;

  localparam int SLOTS = 16;
  localparam int IDW   = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int WW    = 32;

  localparam logic [LW-1:0] NONE_LINK = LW'(SLOTS);

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_SCHED  = 2'd2,
    OP_EXIT   = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADTGT   = 3'd2;
  localparam logic [2:0] ST_HALTED   = 3'd3;
  localparam logic [2:0] ST_NOCHANGE = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_EXIT_UNL = 8'b0000_0100,
    S_POP      = 8'b0000_1000,
    S_PUSH     = 8'b0001_0000,
    S_UNL_TGT  = 8'b0010_0000,
    S_RD       = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

endpackage

// ----- rtl/core/fts_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/fifo_thread_scheduler_core.sv -----
// FIFO ready-queue thread scheduler: slot table, linked ready queue, command sequencer.
// Paths: yield pushes and switches, sched pops the queue head, exit unlinks then pops,
// create scans for a free slot then pushes; a halted scheduler only reads out its result.
// Throughput: one command at a time; in_ready returns the cycle after the result is loaded.
// Reset: slot 0 valid and running, queue empty, not halted; start words read as zero
// until a slot is created (per-slot written flags, no clearing pass).
`timescale 1ns / 1ps
module fifo_thread_scheduler_core
  import fts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_operation,
  input  logic [7:0]      in_target,
  input  logic [31:0]     in_entry_addr,
  input  logic [31:0]     in_start_param,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_status,
  output logic [3:0]      out_thread_id,
  output logic [3:0]      out_running_thread,
  output logic [3:0]      out_previous_thread,
  output logic            out_switched,
  output logic            out_by_scheduler,
  output logic [31:0]     out_run_entry,
  output logic [31:0]     out_run_param,
  output logic [4:0]      out_ready_count
);

  state_t state_r;

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] written_r;
  logic [LW-1:0]    prev_r [SLOTS];
  logic [LW-1:0]    next_r [SLOTS];
  logic [LW-1:0]    head_r, tail_r;
  logic [CW-1:0]    count_r;
  logic [IDW-1:0]   cur_r, last_run_r, last_created_r;
  logic             halted_r;

  op_t              op_r;
  logic [IDW-1:0]   tgt_r, push_r, idx_r, cnt_r;
  logic [WW-1:0]    ent_r, par_r;
  logic [2:0]       status_r;
  logic [IDW-1:0]   tid_r;
  logic             sw_r, bys_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [3:0]       out_tid_r, out_run_r, out_prev_r;
  logic             out_sw_r, out_bys_r;
  logic [WW-1:0]    out_ent_r, out_par_r;
  logic [CW-1:0]    out_count_r;

  logic             ram_we, ram_re;
  logic [IDW-1:0]   ram_addr;
  logic [2*WW-1:0]  ram_rdata;
  logic             rd_written_r;

  function automatic logic lnk_ok(input logic [LW-1:0] l);
    return l < NONE_LINK;
  endfunction

  function automatic logic [IDW-1:0] lidx(input logic [LW-1:0] l);
    return l[IDW-1:0];
  endfunction

  function automatic logic [IDW-1:0] inc_id(input logic [IDW-1:0] v);
    return (v == IDW'(SLOTS - 1)) ? '0 : v + 1'b1;
  endfunction

  logic             in_fire;
  logic             tgt_bad;
  logic             load_out;
  logic             ul_q, ps_q;
  logic [IDW-1:0]   ul_t;
  logic [LW-1:0]    ul_p, ul_n;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign tgt_bad  = (9'(in_target) >= 9'(SLOTS)) || !valid_r[in_target[IDW-1:0]];
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Operand of the unlink done in the current state
  always_comb begin
    case (state_r)
      S_EXIT_UNL: ul_t = cur_r;
      S_POP:      ul_t = lidx(head_r);
      default:    ul_t = tgt_r;
    endcase
    ul_q = ((LW'(ul_t) == head_r) || lnk_ok(prev_r[ul_t]));
    ul_p = prev_r[ul_t];
    ul_n = next_r[ul_t];
    ps_q = (LW'(push_r) == head_r) || lnk_ok(prev_r[push_r]);
  end

  assign ram_we   = (state_r == S_SCAN) && !valid_r[idx_r];
  assign ram_re   = (state_r == S_RD);
  assign ram_addr = ram_we ? idx_r : cur_r;

  fts_ram #(.WIDTH(2 * WW), .DEPTH(SLOTS)) u_words (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata ({ent_r, par_r}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      valid_r        <= SLOTS'(1);
      written_r      <= '0;
      head_r         <= NONE_LINK;
      tail_r         <= NONE_LINK;
      count_r        <= '0;
      cur_r          <= '0;
      last_run_r     <= '0;
      last_created_r <= '0;
      halted_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        prev_r[i] <= NONE_LINK;
        next_r[i] <= NONE_LINK;
      end
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // shared unlink, used by the exit, pop and target states
      if ((state_r == S_EXIT_UNL || state_r == S_POP || state_r == S_UNL_TGT) && ul_q
          && !(state_r == S_POP && !lnk_ok(head_r))) begin
        if (lnk_ok(ul_p)) next_r[lidx(ul_p)] <= ul_n;
        else head_r <= ul_n;
        if (lnk_ok(ul_n)) prev_r[lidx(ul_n)] <= ul_p;
        else tail_r <= ul_p;
        prev_r[ul_t] <= NONE_LINK;
        next_r[ul_t] <= NONE_LINK;
        if (count_r != '0) count_r <= count_r - 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r   <= op_t'(in_operation);
            tgt_r  <= in_target[IDW-1:0];
            ent_r  <= in_entry_addr;
            par_r  <= in_start_param;
            sw_r   <= 1'b0;
            bys_r  <= 1'b0;
            tid_r  <= '0;
            idx_r  <= inc_id(last_created_r);
            cnt_r  <= '0;
            push_r <= cur_r;
            if (halted_r) begin
              status_r <= ST_HALTED;
              state_r  <= S_RD;
            end else begin
              case (op_t'(in_operation))
                OP_CREATE: state_r <= S_SCAN;
                OP_YIELD: begin
                  if (tgt_bad) begin
                    status_r <= ST_BADTGT;
                    state_r  <= S_RD;
                  end else if (in_target[IDW-1:0] == cur_r) begin
                    status_r <= ST_NOCHANGE;
                    tid_r    <= cur_r;
                    state_r  <= S_RD;
                  end else begin
                    status_r <= ST_OK;
                    tid_r    <= in_target[IDW-1:0];
                    sw_r     <= 1'b1;
                    state_r  <= S_PUSH;
                  end
                end
                OP_SCHED: state_r <= S_POP;
                default:  state_r <= S_EXIT_UNL;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r]   <= 1'b1;
            written_r[idx_r] <= 1'b1;
            last_created_r   <= idx_r;
            push_r           <= idx_r;
            tid_r            <= idx_r;
            status_r         <= ST_OK;
            state_r          <= S_PUSH;
          end else if (cnt_r == IDW'(SLOTS - 1)) begin
            status_r <= ST_FULL;
            state_r  <= S_RD;
          end else begin
            idx_r <= inc_id(idx_r);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EXIT_UNL: begin
          // links of the running thread are already clear unless the unlink above clears them
          valid_r[cur_r]   <= 1'b0;
          written_r[cur_r] <= 1'b0;
          state_r          <= S_POP;
        end
        S_POP: begin
          if (!lnk_ok(head_r)) begin
            if (op_r == OP_EXIT) begin
              halted_r <= 1'b1;
              status_r <= ST_HALTED;
            end else begin
              status_r <= ST_NOCHANGE;
              tid_r    <= cur_r;
            end
            state_r <= S_RD;
          end else if (lidx(head_r) == cur_r) begin
            status_r <= ST_NOCHANGE;
            tid_r    <= cur_r;
            state_r  <= S_RD;
          end else begin
            tgt_r    <= lidx(head_r);
            tid_r    <= lidx(head_r);
            status_r <= ST_OK;
            sw_r     <= 1'b1;
            bys_r    <= 1'b1;
            state_r  <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (valid_r[push_r] && !ps_q) begin
            next_r[push_r] <= NONE_LINK;
            if (!lnk_ok(head_r)) begin
              prev_r[push_r] <= NONE_LINK;
              head_r         <= LW'(push_r);
            end else begin
              if (lnk_ok(tail_r)) next_r[lidx(tail_r)] <= LW'(push_r);
              prev_r[push_r] <= tail_r;
            end
            tail_r  <= LW'(push_r);
            count_r <= count_r + 1'b1;
          end
          state_r <= sw_r ? S_UNL_TGT : S_RD;
        end
        S_UNL_TGT: begin
          last_run_r <= cur_r;
          cur_r      <= tgt_r;
          state_r    <= S_RD;
        end
        S_RD: begin
          rd_written_r <= written_r[cur_r];
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_tid_r    <= 4'(tid_r);
      out_run_r    <= 4'(cur_r);
      out_prev_r   <= 4'(last_run_r);
      out_sw_r     <= sw_r;
      out_bys_r    <= bys_r;
      out_ent_r    <= rd_written_r ? ram_rdata[2*WW-1:WW] : '0;
      out_par_r    <= rd_written_r ? ram_rdata[WW-1:0] : '0;
      out_count_r  <= count_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_thread_id       = out_tid_r;
  assign out_running_thread  = out_run_r;
  assign out_previous_thread = out_prev_r;
  assign out_switched        = out_sw_r;
  assign out_by_scheduler    = out_bys_r;
  assign out_run_entry       = out_ent_r;
  assign out_run_param       = out_par_r;
  assign out_ready_count     = 5'(out_count_r);

endmodule
